>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// shared sizes, codes and controller/datapath handshake types for the
// text console character writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [15:0]       t_cell;

    localparam t_addr COL_ADDR       = t_addr'(COLUMNS);
    localparam t_addr FILL_LAST_ADDR = t_addr'(CELL_COUNT - 1);
    localparam t_addr SCRL_LAST_ADDR = t_addr'(CELL_COUNT - COLUMNS - 1);

    // operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // special character codes
    localparam logic [7:0] CH_IGNORE    = 8'hff;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // capture the input beat
        logic wr_cur;       // write the cell under the cursor
        logic wr_prev;      // zero the cell before the cursor
        logic step;         // advance cursor for the latched character
        logic sweep_clr;    // restart the sweep counter
        logic fill;         // one fill write at the sweep counter
        logic fill_zero;    // fill with zero instead of the blank cell
        logic scroll;       // one scroll read at counter plus one row
        logic scroll_home;  // cursor to column 1 of the second last row
        logic home;         // cursor to (1,1)
        logic push;         // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic ch_ignore;
        logic ch_bs;
        logic need_scroll;
        logic fill_last;
        logic scroll_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hdl/tcw_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cmd_if
// command channel: operation, character and read position
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, output operation, output char_code,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input read_row, input read_col, output ready);
endinterface

>>> hdl/tcw_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// response channel: cursor position and read cell
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cell_char, output cell_attr, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cell_char, input cell_attr, output ready);
endinterface

>>> hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: decodes each command beat and steps the datapath through
// cell writes, scroll and fill sweeps
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_BS_PREV,
        S_CHECK,
        S_SCROLL,
        S_SCROLL_TAIL,
        S_CLEAR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.is_put && i_sts.ch_ignore) begin
                    n_state = S_FINISH;
                end else if (i_sts.is_put) begin
                    o_cmd.wr_cur = 1'b1;
                    if (i_sts.ch_bs) begin
                        n_state = S_BS_PREV;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_CHECK;
                    end
                end else if (i_sts.is_clear) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = S_CLEAR;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_BS_PREV: begin
                o_cmd.wr_prev = 1'b1;
                o_cmd.step    = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.need_scroll) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = S_SCROLL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_sts.scroll_last) begin
                    n_state = S_SCROLL_TAIL;
                end
            end
            S_SCROLL_TAIL: begin
                o_cmd.scroll_home = 1'b1;
                n_state           = S_FINISH;
            end
            S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.home = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// cell store, cursor, attribute register, sweep counter and result register
// ----------------------------------------------------------------------------
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr
);

    t_cell mem [CELL_COUNT];

    logic [1:0] r_op;
    logic [7:0] r_char;
    logic [4:0] r_rrow;
    logic [6:0] r_rcol;
    logic [6:0] r_col;
    logic [4:0] r_row;
    logic [7:0] r_attr;
    t_addr      r_cnt;
    logic       r_pend;
    t_addr      r_pend_addr;
    t_cell      r_rd_data;
    logic       r_o_valid;
    logic [6:0] r_o_col;
    logic [4:0] r_o_row;
    logic [7:0] r_o_char;
    logic [7:0] r_o_attr;

    t_addr      cur_idx;
    t_addr      rd_idx;
    logic       rd_in_range;
    logic       rd_ok;
    logic       ch_bs;
    logic       ch_nl;
    logic [7:0] col_inc;
    logic [6:0] n_col;
    logic [4:0] n_row;
    logic       we;
    t_addr      waddr;
    t_cell      wdata;
    t_addr      raddr;

    assign ch_bs = (r_char == CH_BACKSPACE);
    assign ch_nl = (r_char == CH_NEWLINE);

    // cursor is always inside the store once decoded
    assign cur_idx     = t_addr'(r_row) * COL_ADDR + t_addr'(r_col);
    assign rd_in_range = (int'(r_rrow) < ROWS) && (int'(r_rcol) < COLUMNS);
    assign rd_idx      = rd_in_range ? (t_addr'(r_rrow) * COL_ADDR + t_addr'(r_rcol)) : '0;
    assign rd_ok       = (r_op == OP_READ) && rd_in_range;

    // cursor advance for the latched character
    assign col_inc = {1'b0, r_col} + 8'd1;
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (ch_bs) begin
            if (r_col <= 7'd1) begin
                n_col = 7'(COLUMNS - 1);
                n_row = (r_row != 5'd0) ? (r_row - 5'd1) : 5'd0;
            end else begin
                n_col = r_col - 7'd1;
            end
        end else if (ch_nl) begin
            n_col = 7'd1;
            n_row = r_row + 5'd1;
        end else begin
            if (int'(col_inc) >= COLUMNS - 1) begin
                n_col = 7'd1;
                n_row = r_row + 5'd1;
            end else begin
                n_col = col_inc[6:0];
            end
        end
    end

    // single write port
    always_comb begin
        we    = 1'b0;
        waddr = cur_idx;
        wdata = '0;
        priority if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = i_cmd.fill_zero ? '0 : {r_attr, 8'h00};
        end else if (r_pend) begin
            we    = 1'b1;
            waddr = r_pend_addr;
            wdata = r_rd_data;
        end else if (i_cmd.wr_cur) begin
            we    = 1'b1;
            waddr = cur_idx;
            wdata = (ch_bs || ch_nl) ? {r_attr, 8'h00} : {r_attr, r_char};
        end else if (i_cmd.wr_prev) begin
            we    = 1'b1;
            waddr = cur_idx - t_addr'(1);
            wdata = '0;
        end else begin
            we = 1'b0;
        end
    end

    assign raddr = i_cmd.scroll ? (r_cnt + COL_ADDR) : rd_idx;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    // input beat capture and scroll write-back address
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        r_pend_addr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= 7'd1;
            r_row     <= 5'd1;
            r_attr    <= ATTR_RESET;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            priority if (i_cmd.home) begin
                r_col <= 7'd1;
                r_row <= 5'd1;
            end else if (i_cmd.scroll_home) begin
                r_col <= 7'd1;
                r_row <= 5'(ROWS - 2);
            end else if (i_cmd.step) begin
                r_col <= n_col;
                r_row <= n_row;
            end else begin
                r_col <= r_col;
            end
            priority if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.fill || i_cmd.scroll) begin
                r_cnt <= r_cnt + t_addr'(1);
            end else begin
                r_cnt <= r_cnt;
            end
            r_pend <= i_cmd.scroll;
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_col  <= r_col;
            r_o_row  <= r_row;
            r_o_char <= rd_ok ? r_rd_data[7:0] : 8'h00;
            r_o_attr <= rd_ok ? r_rd_data[15:8] : 8'h00;
        end
    end

    assign o_sts.is_put      = (r_op == OP_PUT);
    assign o_sts.is_clear    = (r_op == OP_CLEAR);
    assign o_sts.ch_ignore   = (r_char == CH_IGNORE);
    assign o_sts.ch_bs       = ch_bs;
    assign o_sts.need_scroll = (int'(r_row) >= ROWS - 1);
    assign o_sts.fill_last   = (r_cnt == FILL_LAST_ADDR);
    assign o_sts.scroll_last = (r_cnt == SCRL_LAST_ADDR);
    assign o_sts.out_free    = !r_o_valid || i_rsp_ready;

    assign o_rsp_valid  = r_o_valid;
    assign o_cursor_col = r_o_col;
    assign o_cursor_row = r_o_row;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;

endmodule

>>> hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
// sequence: a read, ignored char or unused op goes from dispatch to finish; a put or
//   newline passes the check state on the way, and a backspace the back-step state too
// the next beat is taken the cycle after the result is loaded, so a new beat is never
//   taken before the last one is through; finish waits while an untaken result holds the register
// a put that reaches the last row adds a scroll sweep; clear adds a fill sweep
// reset: synchronous; then an init pass zeroes the whole store with i_cmd.ready low
// ----------------------------------------------------------------------------
// text_console_char_writer
// text console with an 80x25 character/attribute cell store and cursor;
// put character, clear screen and cell read over a valid/ready channel
// ----------------------------------------------------------------------------
module text_console_char_writer
    import tcw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    tcw_cmd_if.sink       i_cmd,
    tcw_rsp_if.source     o_rsp
);

    // control/status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    // command beats are taken only while the sequencer sits idle
    assign i_cmd.ready = in_ready;

    // sequencer: init sweep, decode, cell writes, scroll and clear sweeps
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // cell store, cursor, attribute and the result register that lets the
    // response wait without holding up the sequencer's next command
    tcw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_cmd.operation),
        .i_char_code   (i_cmd.char_code),
        .i_read_row    (i_cmd.read_row),
        .i_read_col    (i_cmd.read_col),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_cursor_col  (o_rsp.cursor_col),
        .o_cursor_row  (o_rsp.cursor_row),
        .o_cell_char   (o_rsp.cell_char),
        .o_cell_attr   (o_rsp.cell_attr)
    );

endmodule

>>> hdl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on the console writer, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [6:0] i_cursor_col,
    input logic [4:0] i_cursor_row,
    input logic [7:0] i_cell_char,
    input logic [7:0] i_cell_attr
);

    // cursor never rests on the last row: it scrolls first
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (int'(i_cursor_row) <= ROWS - 2))
        else $error("cursor row on last row");

    // cursor column stays in 1..COLUMNS-1
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_cursor_col != 7'd0) && (int'(i_cursor_col) <= COLUMNS - 1))
        else $error("cursor column out of range");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command ready while busy");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_cursor_col)
            && $stable(i_cursor_row) && $stable(i_cell_char) && $stable(i_cell_attr))
        else $error("stalled response changed");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_cursor_col (o_rsp.cursor_col),
    .i_cursor_row (o_rsp.cursor_row),
    .i_cell_char  (o_rsp.cell_char),
    .i_cell_attr  (o_rsp.cell_attr)
);
